// File: design/esc_pkg.sv
// shared types and constants for the elevator scan controller
// no dependencies; used by esc_step, the top level and the checker
package esc_pkg;

  localparam int MAX_FLOORS = 16;
  localparam int FLOOR_W    = 4;
  localparam int FIU_W      = 5;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_CAR_BTN   = 2'd1,
    OP_HALL_UP   = 2'd2,
    OP_HALL_DOWN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_STAND = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DOWN  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    DOOR_CLOSED  = 2'd0,
    DOOR_OPENING = 2'd1,
    DOOR_DWELL   = 2'd2,
    DOOR_CLOSING = 2'd3
  } door_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOORS_IN_USE = 2'd0,
    CFG_MOVE_TICKS    = 2'd1,
    CFG_DOOR_TICKS    = 2'd2,
    CFG_DWELL_TICKS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [FIU_W-1:0]  floors_in_use;
    logic [TICK_W-1:0] move_ticks;
    logic [TICK_W-1:0] door_ticks;
    logic [TICK_W-1:0] dwell_ticks;
  } esc_cfg_t;

  typedef struct packed {
    logic [FLOOR_W-1:0]    floor_pos;
    dir_t                  dir;
    logic [TICK_W-1:0]     motor_count;
    door_t                 door_stage;
    logic [TICK_W-1:0]     door_count;
    logic [MAX_FLOORS-1:0] pending;
    logic [MAX_FLOORS-1:0] lamps;
  } esc_state_t;

  // what one result item carries
  typedef struct packed {
    logic [FLOOR_W-1:0]    current_floor;
    logic [1:0]            direction;
    logic                  motor_running;
    logic [1:0]            door_phase;
    logic [MAX_FLOORS-1:0] pending_floors;
    logic [MAX_FLOORS-1:0] car_lamps;
  } esc_result_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    at_least_one = (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

// File: design/esc_step.sv
// next-state logic for one item: request capture, countdowns, idle decision
// depends on esc_pkg
module esc_step (
  input  esc_pkg::esc_state_t        cur,
  input  esc_pkg::esc_cfg_t          cfg,
  input  logic [1:0]                 operation,
  input  logic [esc_pkg::FLOOR_W-1:0] floor,
  output esc_pkg::esc_state_t        nxt
);

  logic [esc_pkg::FIU_W-1:0]      served;
  logic [esc_pkg::MAX_FLOORS-1:0] here;
  logic [esc_pkg::MAX_FLOORS-1:0] below;
  logic [esc_pkg::MAX_FLOORS-1:0] above;
  logic [esc_pkg::TICK_W-1:0]     door_dec;
  logic [esc_pkg::TICK_W-1:0]     door_min;
  esc_pkg::dir_t                  dir_sel;
  logic                           go_up;
  esc_pkg::op_t                   op;

  assign op       = esc_pkg::op_t'(operation);
  assign served   = (cfg.floors_in_use > esc_pkg::FIU_W'(esc_pkg::MAX_FLOORS))
                    ? esc_pkg::FIU_W'(esc_pkg::MAX_FLOORS) : cfg.floors_in_use;
  assign here     = esc_pkg::MAX_FLOORS'(1) << cur.floor_pos;
  assign below    = cur.pending & (here - esc_pkg::MAX_FLOORS'(1));
  assign above    = cur.pending & ~((here << 1) - esc_pkg::MAX_FLOORS'(1));
  assign door_dec = (cur.door_count != '0) ? cur.door_count - esc_pkg::TICK_W'(1) : '0;
  assign door_min = esc_pkg::at_least_one(cfg.door_ticks);

  // standing: head for the lowest pending floor, which lies above iff nothing is below
  always_comb begin
    if (cur.dir == esc_pkg::DIR_UP || cur.dir == esc_pkg::DIR_DOWN) begin
      dir_sel = cur.dir;
    end else begin
      dir_sel = (below == '0) ? esc_pkg::DIR_UP : esc_pkg::DIR_DOWN;
    end
    if (dir_sel == esc_pkg::DIR_UP) begin
      go_up = (above != '0);
    end else begin
      go_up = (below == '0);
    end
  end

  always_comb begin
    nxt = cur;
    if (op == esc_pkg::OP_TICK) begin
      if (cur.motor_count != '0) begin
        nxt.motor_count = cur.motor_count - esc_pkg::TICK_W'(1);
      end else if (cur.door_stage != esc_pkg::DOOR_CLOSED) begin
        nxt.door_count = door_dec;
        if (door_dec == '0) begin
          unique case (cur.door_stage)
            esc_pkg::DOOR_OPENING: begin
              if (cfg.dwell_ticks == '0) begin
                nxt.door_stage = esc_pkg::DOOR_CLOSING;
                nxt.door_count = door_min;
              end else begin
                nxt.door_stage = esc_pkg::DOOR_DWELL;
                nxt.door_count = cfg.dwell_ticks;
              end
            end
            esc_pkg::DOOR_DWELL: begin
              nxt.door_stage = esc_pkg::DOOR_CLOSING;
              nxt.door_count = door_min;
            end
            default: begin
              nxt.door_stage = esc_pkg::DOOR_CLOSED;
            end
          endcase
        end
      end else if (cur.pending == '0) begin
        nxt.dir = esc_pkg::DIR_STAND;
      end else if ((cur.pending & here) != '0) begin
        nxt.pending    = cur.pending & ~here;
        nxt.lamps      = cur.lamps & ~here;
        nxt.door_stage = esc_pkg::DOOR_OPENING;
        nxt.door_count = door_min;
      end else begin
        nxt.dir         = dir_sel;
        nxt.floor_pos   = go_up ? cur.floor_pos + esc_pkg::FLOOR_W'(1)
                                : cur.floor_pos - esc_pkg::FLOOR_W'(1);
        nxt.motor_count = esc_pkg::at_least_one(cfg.move_ticks);
      end
    end else if ({1'b0, floor} < served) begin
      nxt.pending = cur.pending | (esc_pkg::MAX_FLOORS'(1) << floor);
      if (op == esc_pkg::OP_CAR_BTN) begin
        nxt.lamps = cur.lamps | (esc_pkg::MAX_FLOORS'(1) << floor);
      end
    end
  end

endmodule

// File: design/elevator_scan_controller.sv
// top level of the elevator scan controller: state registers, config, output skid
// depends on esc_pkg and esc_step
//
// usage
//   input items (in_operation, in_floor) are ticks, car buttons and hall calls;
//   each accepted item (in_valid high, in_stall low) yields exactly one result
//   item with the car state after that item is applied
//   the result is registered and shows on the out_ ports from the output register
//   throughput: one item per cycle while in_stall is low; the car state is
//   updated in the cycle an item is accepted, so the next item sees it straight away
//   the result side has an output register plus one skid register: while the
//   receiver stalls, one more item is still taken; in_stall rises once the
//   skid register is full and falls when the receiver drains it
//   reset (rst_n low, synchronous) empties both result registers, clears all
//   car state and loads the default configuration (16 floors, 12 move ticks,
//   10 door ticks, 20 dwell ticks)
//   cfg_we writes register cfg_index with cfg_wdata, no read-back
module elevator_scan_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic [esc_pkg::FLOOR_W-1:0]      in_floor,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [esc_pkg::FLOOR_W-1:0]      out_current_floor,
  output logic [1:0]                       out_direction,
  output logic                             out_motor_running,
  output logic [1:0]                       out_door_phase,
  output logic [esc_pkg::MAX_FLOORS-1:0]   out_pending_floors,
  output logic [esc_pkg::MAX_FLOORS-1:0]   out_car_lamps,
  input  logic                             cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  esc_pkg::esc_cfg_t    cfg_r;
  esc_pkg::esc_state_t  state_r;
  esc_pkg::esc_state_t  state_nxt;
  esc_pkg::esc_result_t result;
  esc_pkg::esc_result_t out_r;
  esc_pkg::esc_result_t skid_r;
  logic                 out_valid_r;
  logic                 skid_valid_r;
  logic                 in_take;
  logic                 out_take;

  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floors_in_use <= esc_pkg::FIU_W'(16);
      cfg_r.move_ticks    <= esc_pkg::TICK_W'(12);
      cfg_r.door_ticks    <= esc_pkg::TICK_W'(10);
      cfg_r.dwell_ticks   <= esc_pkg::TICK_W'(20);
    end else if (cfg_we) begin
      unique case (esc_pkg::cfg_idx_t'(cfg_index))
        esc_pkg::CFG_FLOORS_IN_USE: cfg_r.floors_in_use <= cfg_wdata[esc_pkg::FIU_W-1:0];
        esc_pkg::CFG_MOVE_TICKS:    cfg_r.move_ticks    <= cfg_wdata;
        esc_pkg::CFG_DOOR_TICKS:    cfg_r.door_ticks    <= cfg_wdata;
        esc_pkg::CFG_DWELL_TICKS:   cfg_r.dwell_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // all per-item work happens here in a single pass
  esc_step u_step (
    .cur       (state_r),
    .cfg       (cfg_r),
    .operation (in_operation),
    .floor     (in_floor),
    .nxt       (state_nxt)
  );

  assign result.current_floor  = state_nxt.floor_pos;
  assign result.direction      = state_nxt.dir;
  assign result.motor_running  = (state_nxt.motor_count != '0);
  assign result.door_phase     = state_nxt.door_stage;
  assign result.pending_floors = state_nxt.pending;
  assign result.car_lamps      = state_nxt.lamps;

  // car state moves on with every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.floor_pos   <= '0;
      state_r.dir         <= esc_pkg::DIR_STAND;
      state_r.motor_count <= '0;
      state_r.door_stage  <= esc_pkg::DOOR_CLOSED;
      state_r.door_count  <= '0;
      state_r.pending     <= '0;
      state_r.lamps       <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // output register and skid stage; order is kept because the skid entry
  // always goes to the output before any newer item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  assign out_current_floor  = out_r.current_floor;
  assign out_direction      = out_r.direction;
  assign out_motor_running  = out_r.motor_running;
  assign out_door_phase     = out_r.door_phase;
  assign out_pending_floors = out_r.pending_floors;
  assign out_car_lamps      = out_r.car_lamps;

endmodule

// File: design/esc_checker.sv
// port-level checks for the elevator scan controller, bound to the top level
// depends on esc_pkg
module esc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [esc_pkg::FLOOR_W-1:0]    out_current_floor,
  input logic [1:0]                     out_direction,
  input logic                           out_motor_running,
  input logic [1:0]                     out_door_phase,
  input logic [esc_pkg::MAX_FLOORS-1:0] out_pending_floors,
  input logic [esc_pkg::MAX_FLOORS-1:0] out_car_lamps
);

  // motor and door never busy together
  a_motor_door: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_running |-> out_door_phase == esc_pkg::DOOR_CLOSED)
    else $error("motor running with door not closed");

  // a moving car always has a travel direction
  a_motor_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_running |-> out_direction != esc_pkg::DIR_STAND)
    else $error("motor running while standing");

  // a lit lamp always has a pending request behind it
  a_lamp_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_car_lamps & ~out_pending_floors) == '0)
    else $error("lamp lit for a floor not pending");

  // stalled result stays valid and holds its floor, pending floors and door phase
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_floor)
      && $stable(out_pending_floors) && $stable(out_door_phase))
    else $error("stalled result changed");

endmodule

bind elevator_scan_controller esc_checker u_esc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_current_floor  (out_current_floor),
  .out_direction      (out_direction),
  .out_motor_running  (out_motor_running),
  .out_door_phase     (out_door_phase),
  .out_pending_floors (out_pending_floors),
  .out_car_lamps      (out_car_lamps)
);

// File: verif/car_state_checker.sv
// checker for the elevator scan controller: mirrors the car state, predicts each
// result item and compares it with the result channel; depends on esc_pkg
module car_state_checker
  import esc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [FLOOR_W-1:0]    in_floor,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [FLOOR_W-1:0]    out_current_floor,
  input  logic [1:0]            out_direction,
  input  logic                  out_motor_running,
  input  logic [1:0]            out_door_phase,
  input  logic [MAX_FLOORS-1:0] out_pending_floors,
  input  logic [MAX_FLOORS-1:0] out_car_lamps,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    awaiting,
  output logic                  car_at_rest,
  output logic [FLOOR_W-1:0]    car_floor
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirrored registers
  logic [FIU_W-1:0]      served_limit;
  logic [TICK_W-1:0]     travel_ticks;
  logic [TICK_W-1:0]     door_run_ticks;
  logic [TICK_W-1:0]     dwell_len;

  // mirrored car state
  logic [FLOOR_W-1:0]    pos;
  dir_t                  heading;
  logic [TICK_W-1:0]     motor_left;
  door_t                 door_state;
  logic [TICK_W-1:0]     door_left;
  logic [MAX_FLOORS-1:0] pending;
  logic [MAX_FLOORS-1:0] lamps;

  esc_result_t expected_views[$];

  function automatic logic [TICK_W-1:0] ticks_or_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  task automatic reset_car();
    served_limit   = 5'd16;
    travel_ticks   = 16'd12;
    door_run_ticks = 16'd10;
    dwell_len      = 16'd20;
    pos            = '0;
    heading        = DIR_STAND;
    motor_left     = '0;
    door_state     = DOOR_CLOSED;
    door_left      = '0;
    pending        = '0;
    lamps          = '0;
  endtask

  task automatic step_door();
    if (door_left != '0) door_left--;
    if (door_left == '0) begin
      case (door_state)
        DOOR_OPENING: begin
          if (dwell_len == '0) begin
            door_state = DOOR_CLOSING;
            door_left  = ticks_or_one(door_run_ticks);
          end else begin
            door_state = DOOR_DWELL;
            door_left  = dwell_len;
          end
        end
        DOOR_DWELL: begin
          door_state = DOOR_CLOSING;
          door_left  = ticks_or_one(door_run_ticks);
        end
        default: door_state = DOOR_CLOSED;
      endcase
    end
  endtask

  // one decision with motor and door both at rest
  task automatic decide_move();
    int lo_above;
    int hi_below;
    int lowest;
    int target;
    lo_above = -1;
    hi_below = -1;
    lowest   = -1;
    if (pending == '0) begin
      heading = DIR_STAND;
    end else if (pending[pos]) begin
      pending[pos] = 1'b0;
      lamps[pos]   = 1'b0;
      door_state   = DOOR_OPENING;
      door_left    = ticks_or_one(door_run_ticks);
    end else begin
      for (int i = 0; i < MAX_FLOORS; i++) begin
        if (pending[i]) begin
          if (lowest < 0) lowest = i;
          if (i > int'(pos) && lo_above < 0) lo_above = i;
          if (i < int'(pos)) hi_below = i;
        end
      end
      // leaving standstill: head for the lowest waiting floor
      if (heading != DIR_UP && heading != DIR_DOWN)
        heading = (lowest > int'(pos)) ? DIR_UP : DIR_DOWN;
      if (heading == DIR_UP) target = (lo_above >= 0) ? lo_above : hi_below;
      else target = (hi_below >= 0) ? hi_below : lo_above;
      if (target >= 0) begin
        if (target > int'(pos)) pos++;
        else pos--;
        motor_left = ticks_or_one(travel_ticks);
      end
    end
  endtask

  task automatic advance_car(input op_t op, input logic [FLOOR_W-1:0] fl);
    int served;
    served = (int'(served_limit) > MAX_FLOORS) ? MAX_FLOORS : int'(served_limit);
    if (op == OP_TICK) begin
      if (motor_left != '0) motor_left--;
      else if (door_state != DOOR_CLOSED) step_door();
      else decide_move();
    end else if (int'(fl) < served) begin
      pending[fl] = 1'b1;
      if (op == OP_CAR_BTN) lamps[fl] = 1'b1;
    end
  endtask

  function automatic esc_result_t car_view();
    esc_result_t r;
    r.current_floor  = pos;
    r.direction      = heading;
    r.motor_running  = (motor_left != '0);
    r.door_phase     = door_state;
    r.pending_floors = pending;
    r.car_lamps      = lamps;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    esc_result_t want;
    if (!rst_n) begin
      reset_car();
      expected_views.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("current_floor", 16'(want.current_floor), 16'(out_current_floor));
          check_field("direction", 16'(want.direction), 16'(out_direction));
          check_field("motor_running", 16'(want.motor_running), 16'(out_motor_running));
          check_field("door_phase", 16'(want.door_phase), 16'(out_door_phase));
          check_field("pending_floors", want.pending_floors, out_pending_floors);
          check_field("car_lamps", want.car_lamps, out_car_lamps);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FLOORS_IN_USE: served_limit   = cfg_wdata[FIU_W-1:0];
          CFG_MOVE_TICKS:    travel_ticks   = cfg_wdata;
          CFG_DOOR_TICKS:    door_run_ticks = cfg_wdata;
          CFG_DWELL_TICKS:   dwell_len      = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_car(op_t'(in_operation), in_floor);
        expected_views.insert(expected_views.size(), car_view());
      end
    end
    awaiting    = expected_views.size();
    car_floor   = pos;
    car_at_rest = (motor_left == '0) && (door_state == DOOR_CLOSED) &&
                  (pending == '0) && (heading == DIR_STAND);
  end

endmodule

// File: verif/tb.sv
// top of the elevator scan controller testbench: clock, reset, item and register
// stimulus, receiver stalls and the verdict; depends on esc_pkg and car_state_checker
module tb;
  import esc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_operation;
  logic [FLOOR_W-1:0]    in_floor;
  logic                  out_valid;
  logic                  out_stall;
  logic [FLOOR_W-1:0]    out_current_floor;
  logic [1:0]            out_direction;
  logic                  out_motor_running;
  logic [1:0]            out_door_phase;
  logic [MAX_FLOORS-1:0] out_pending_floors;
  logic [MAX_FLOORS-1:0] out_car_lamps;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    fail_count;
  int                    awaiting;
  logic                  car_at_rest;
  logic [FLOOR_W-1:0]    car_floor;

  // quiet: no gaps and no stalls; squeeze: one long receiver hold-off
  bit                    quiet;
  bit                    squeeze;
  int                    run_left;

  elevator_scan_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_floor           (in_floor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_floor  (out_current_floor),
    .out_direction      (out_direction),
    .out_motor_running  (out_motor_running),
    .out_door_phase     (out_door_phase),
    .out_pending_floors (out_pending_floors),
    .out_car_lamps      (out_car_lamps),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  car_state_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_floor           (in_floor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_floor  (out_current_floor),
    .out_direction      (out_direction),
    .out_motor_running  (out_motor_running),
    .out_door_phase     (out_door_phase),
    .out_pending_floors (out_pending_floors),
    .out_car_lamps      (out_car_lamps),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .awaiting           (awaiting),
    .car_at_rest        (car_at_rest),
    .car_floor          (car_floor)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall bursts, free-running stretches, one long hold-off
  initial begin
    bit squeezed;
    squeezed  = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        // long hold-off so the skid fills and the block stalls its input
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        squeezed = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // offer one item from a falling edge and hold it until it is taken
  task automatic send_item(input op_t op, input logic [FLOOR_W-1:0] fl);
    if (!quiet && run_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      run_left = $urandom_range(1, 20);
    end
    if (run_left > 0) run_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_floor     <= fl;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  // all four registers, one write per cycle
  task automatic apply_setting(input int fiu, input int mv, input int dr, input int dw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FLOORS_IN_USE;
    cfg_wdata <= CFG_DATA_W'(fiu);
    @(negedge clk);
    cfg_index <= CFG_MOVE_TICKS;
    cfg_wdata <= CFG_DATA_W'(mv);
    @(negedge clk);
    cfg_index <= CFG_DOOR_TICKS;
    cfg_wdata <= CFG_DATA_W'(dr);
    @(negedge clk);
    cfg_index <= CFG_DWELL_TICKS;
    cfg_wdata <= CFG_DATA_W'(dw);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // every result in, then a short pause
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (awaiting == 0);
    repeat (4) @(negedge clk);
  endtask

  // mostly ticks so the car keeps moving, with requests on any floor
  task automatic run_phase(input int fiu, input int mv, input int dr, input int dw,
                           input int n);
    op_t op;
    drain_results();
    apply_setting(fiu, mv, dr, dw);
    for (int k = 0; k < n; k++) begin
      op = ($urandom_range(0, 9) < 6) ? OP_TICK : op_t'($urandom_range(1, 3));
      send_item(op, FLOOR_W'($urandom_range(0, MAX_FLOORS - 1)));
    end
  endtask

  // tick until the car stands empty with motor and door at rest
  task automatic settle_car();
    while (!car_at_rest) send_item(OP_TICK, FLOOR_W'($urandom_range(0, MAX_FLOORS - 1)));
  endtask

  initial begin
    quiet        = 1'b0;
    squeeze      = 1'b0;
    run_left     = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_TICK;
    in_floor     = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_FLOORS_IN_USE;
    cfg_wdata    = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero travel, door and dwell times act as one, dwell skipped
    apply_setting(16, 0, 0, 0);
    send_item(OP_TICK, 4'd9);         // nothing waiting, car stands
    send_item(OP_HALL_UP, 4'd0);      // call at the car's own floor
    send_item(OP_CAR_BTN, 4'd15);     // top floor, lamp lit
    send_item(OP_HALL_DOWN, 4'd7);
    send_item(OP_CAR_BTN, 4'd15);     // repeated request
    send_item(OP_TICK, 4'd0);         // door opens at floor 0
    send_item(OP_CAR_BTN, 4'd0);      // request at the car while the door works
    for (int k = 0; k < 16; k++) send_item(OP_TICK, 4'hf);

    // first random phase with the long receiver hold-off
    drain_results();
    apply_setting(16, 1, 1, 0);
    squeeze = 1'b1;
    for (int k = 0; k < 260; k++)
      send_item(($urandom_range(0, 9) < 6) ? OP_TICK : op_t'($urandom_range(1, 3)),
                FLOOR_W'($urandom_range(0, MAX_FLOORS - 1)));

    run_phase(2, 3, 2, 1, 200);        // two floors served; earlier calls above stay
    run_phase(31, 0, 0, 0, 200);       // oversized floor count, zero timings
    run_phase(0, 2, 1, 1, 160);        // no floor served, backlog still worked off
    run_phase(1, 1, 2, 3, 160);        // only the ground floor served
    run_phase(17, 4, 3, 5, 240);       // just above the floor limit
    run_phase(9, 12, 10, 20, 200);     // reset timings on a mid-size building

    // from here to the end of the run, no gaps and no stalls
    drain_results();
    quiet = 1'b1;
    run_phase(16, 1, 1, 2, 260);

    // longest timings: park the car, call one floor away and run the motor
    // countdown down from its full count for a while
    drain_results();
    apply_setting(16, 1, 1, 0);
    settle_car();
    drain_results();
    apply_setting(16, 65535, 65535, 65535);
    send_item(OP_CAR_BTN, car_floor ^ 4'd1);
    for (int k = 0; k < 40; k++) send_item(OP_TICK, 4'd0);

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
